[hw/rtl/rls_pkg.sv]
`default_nettype none

package rls_pkg;

   // table and layer limits
   localparam int MAX_REGIONS = 256;
   localparam int MAX_LAYERS  = 8;

   // fixed field widths
   localparam int KEY_W          = 7;
   localparam int VEL_W          = 7;
   localparam int LEN_W          = 8;
   localparam int HIT_W          = 32;
   localparam int ENTRY_W        = 8;
   localparam int CFG_W          = 9;
   localparam int REGION_INDEX_W = 8;
   localparam int LAYER_COUNT_W  = 4;

   // derived widths
   localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int NUM_W  = $clog2(MAX_REGIONS + 1);
   localparam int LCNT_W = $clog2(MAX_LAYERS + 1);
   localparam int LPOS_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int RANK_W = VEL_W + KEY_W + IDX_W;

   // modulo pipeline: bits of hit consumed per stage
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = HIT_W / DIV_STEPS;

   // action codes
   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_RESOLVE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] lo_key;
      logic [KEY_W-1:0] hi_key;
      logic [VEL_W-1:0] lo_vel;
      logic [VEL_W-1:0] hi_vel;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] slot;
   } region_type;

   localparam int REGION_W = $bits(region_type);

   // one entry in flight through the modulo pipeline
   typedef struct packed {
      logic              cand;
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  slot_m1;
      logic [LEN_W-1:0]  rem;
      logic [RANK_W-1:0] rank;
   } div_stage_type;

   // restoring remainder steps, msb first
   function automatic logic [LEN_W-1:0] mod_step(input logic [LEN_W-1:0] rem,
                                                  input logic [DIV_STEPS-1:0] bits,
                                                  input logic [LEN_W-1:0] len);
      logic [LEN_W:0]   acc;
      logic [LEN_W-1:0] r;
      r = rem;
      for (int b = DIV_STEPS - 1; b >= 0; b--) begin
         acc = {r, bits[b]};
         if (acc >= {1'b0, len}) begin
            acc = acc - {1'b0, len};
         end
         r = acc[LEN_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rls_req_if.sv]
`default_nettype none

interface rls_req_if;
   import rls_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [ENTRY_W-1:0] entry_index;
   logic [KEY_W-1:0]   lo_key;
   logic [KEY_W-1:0]   hi_key;
   logic [VEL_W-1:0]   lo_vel;
   logic [VEL_W-1:0]   hi_vel;
   logic [LEN_W-1:0]   cycle_length;
   logic [LEN_W-1:0]   cycle_slot;
   logic [KEY_W-1:0]   note;
   logic [VEL_W-1:0]   velocity;
   logic [HIT_W-1:0]   hit;

   modport source (
      output valid, action, entry_index, lo_key, hi_key, lo_vel, hi_vel,
             cycle_length, cycle_slot, note, velocity, hit,
      input  ready
   );

   modport sink (
      input  valid, action, entry_index, lo_key, hi_key, lo_vel, hi_vel,
             cycle_length, cycle_slot, note, velocity, hit,
      output ready
   );

endinterface

`default_nettype wire

[hw/rtl/rls_rsp_if.sv]
`default_nettype none

interface rls_rsp_if;
   import rls_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [REGION_INDEX_W-1:0] region_index;
   logic                      found;
   logic                      last;
   logic [LAYER_COUNT_W-1:0]  layer_count;

   modport source (
      output valid, region_index, found, last, layer_count,
      input  ready
   );

   modport sink (
      input  valid, region_index, found, last, layer_count,
      output ready
   );

endinterface

`default_nettype wire

[hw/rtl/rls_ram.sv]
`default_nettype none

module rls_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/region_layer_selector.sv]
// Region layer selector. A write beat (action 0) stores one region entry in a
// 256 x 44 single-port-write table RAM and returns nothing; length
// and slot are clamped to at least 1, writes beyond the table are dropped. A
// resolve beat (action 1) reads the entries in use (csr regions_in_use, capped
// at the table size) from entry zero, one RAM read per cycle, through a
// registered-read stage and an 8-stage hit-modulo pipeline (4 remainder bits
// per stage), into a sorted list of the best 8 matches. A resolve then scans
// and drains the pipeline, orders the kept entries by index, and then sends
// the result beats (1 to 8 beats) in ascending index order as the sink
// takes them. The scan rate is set by the single RAM read port. The input
// side is ready only while idle; the last result may still sit in the output
// register while the next beat is taken.
// Table contents are undefined until written and there is no clearing pass;
// resolves must only scan written entries.

`default_nettype none

module region_layer_selector (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [rls_pkg::CFG_W-1:0]  csr_wr_data,
   rls_req_if.sink                    req_ch,
   rls_rsp_if.source                  rsp_ch
);

   import rls_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_ORDER = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  cfg_num_ff, cfg_num_in;
   logic [NUM_W-1:0]  scan_num_ff, scan_num_in;
   logic [NUM_W-1:0]  issue_cnt_ff, issue_cnt_in;
   logic [LPOS_W-1:0] emit_cnt_ff, emit_cnt_in;

   // resolve event, held for the whole scan
   logic [KEY_W-1:0]  note_ff, note_in;
   logic [VEL_W-1:0]  vel_ff, vel_in;
   logic [HIT_W-1:0]  hit_ff, hit_in;

   // table ram
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [REGION_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [REGION_W-1:0] ram_rd_data;
   region_type        wr_region;
   region_type        rd_region;

   // read stage and modulo pipeline
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   div_stage_type     stg_ff [DIV_STAGES+1];
   div_stage_type     stg_in [DIV_STAGES+1];
   logic [DIV_STAGES:0] stg_vld_ff, stg_vld_in;
   logic [VEL_W-1:0]  vel_span;
   logic [KEY_W-1:0]  key_span;

   // best list, sorted best first (smallest rank key)
   logic [RANK_W-1:0] best_rank_ff [MAX_LAYERS];
   logic [RANK_W-1:0] best_rank_in [MAX_LAYERS];
   logic [LCNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0]  best_idx [MAX_LAYERS];
   logic [MAX_LAYERS-1:0] beat;
   logic [LPOS_W-1:0] asc_pos_ff [MAX_LAYERS];
   logic [LPOS_W-1:0] asc_pos_in [MAX_LAYERS];
   div_stage_type     fin;
   logic              ins;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   logic [REGION_INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [LAYER_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic              req_acc;
   logic              write_acc;
   logic              resolve_acc;
   logic              scan_more;
   logic              pipe_busy;
   logic              rsp_load;
   logic              is_last;
   logic [MAX_LAYERS-1:0] sel_vec;
   logic [IDX_W-1:0]  sel_idx;

   // ---------------------------------------------------------------------
   // input handshake: one item at a time, taken only while idle
   // ---------------------------------------------------------------------
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign write_acc    = req_acc && (req_ch.action == ACT_WRITE);
   assign resolve_acc  = req_acc && (req_ch.action == ACT_RESOLVE);

   // ---------------------------------------------------------------------
   // table write: clamp length and slot, drop writes beyond the table
   // ---------------------------------------------------------------------
   always_comb begin
      wr_region.lo_key = req_ch.lo_key;
      wr_region.hi_key = req_ch.hi_key;
      wr_region.lo_vel = req_ch.lo_vel;
      wr_region.hi_vel = req_ch.hi_vel;
      wr_region.len    = (req_ch.cycle_length == '0) ? LEN_W'(1) : req_ch.cycle_length;
      wr_region.slot   = (req_ch.cycle_slot == '0) ? LEN_W'(1) : req_ch.cycle_slot;
   end

   assign ram_wr_en   = write_acc && (int'(req_ch.entry_index) < MAX_REGIONS);
   assign ram_wr_addr = IDX_W'(req_ch.entry_index);
   assign ram_wr_data = wr_region;

   // reads only happen in scan and writes only in idle, so no entry is ever
   // read and written in the same cycle
   assign scan_more   = (issue_cnt_ff < scan_num_ff);
   assign ram_rd_en   = (state_ff == ST_SCAN) && scan_more;
   assign ram_rd_addr = issue_cnt_ff[IDX_W-1:0];

   rls_ram #(
      .WIDTH (REGION_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_region = region_type'(ram_rd_data);

   // ---------------------------------------------------------------------
   // range check on the read data, then hit mod length over the pipeline
   // ---------------------------------------------------------------------
   assign vel_span = rd_region.hi_vel - rd_region.lo_vel;
   assign key_span = rd_region.hi_key - rd_region.lo_key;

   assign rd_vld_in = ram_rd_en;
   assign rd_idx_in = ram_rd_addr;

   always_comb begin
      stg_vld_in = {stg_vld_ff[DIV_STAGES-1:0], rd_vld_ff};

      // matched entries have non-negative spans, so unsigned spans rank right;
      // inverting the index makes the higher index win a tie
      stg_in[0].cand    = (note_ff >= rd_region.lo_key) && (note_ff <= rd_region.hi_key) &&
                          (vel_ff >= rd_region.lo_vel) && (vel_ff <= rd_region.hi_vel);
      stg_in[0].len     = rd_region.len;
      // a zero slot wraps to all ones, which no remainder can reach
      stg_in[0].slot_m1 = rd_region.slot - LEN_W'(1);
      stg_in[0].rem     = '0;
      stg_in[0].rank    = {vel_span, key_span, ~rd_idx_ff};

      for (int s = 1; s <= DIV_STAGES; s++) begin
         stg_in[s]     = stg_ff[s-1];
         stg_in[s].rem = mod_step(stg_ff[s-1].rem,
                                  hit_ff[HIT_W-1-(s-1)*DIV_STEPS -: DIV_STEPS],
                                  stg_ff[s-1].len);
      end
   end

   assign pipe_busy = rd_vld_ff || (|stg_vld_ff);

   // ---------------------------------------------------------------------
   // priority insertion into the best list
   // ---------------------------------------------------------------------
   assign fin = stg_ff[DIV_STAGES];
   assign ins = stg_vld_ff[DIV_STAGES] && fin.cand && (fin.rem == fin.slot_m1);

   always_comb begin
      for (int j = 0; j < MAX_LAYERS; j++) begin
         // entries that outrank the newcomer form a prefix of the list
         beat[j]     = (LCNT_W'(j) < best_cnt_ff) && (best_rank_ff[j] < fin.rank);
         best_idx[j] = ~best_rank_ff[j][IDX_W-1:0];
      end
   end

   always_comb begin
      best_rank_in = best_rank_ff;
      best_cnt_in  = best_cnt_ff;
      if (resolve_acc) begin
         best_cnt_in = '0;
      end else if (ins) begin
         // slot zero takes the newcomer unless the head outranks it
         if (!beat[0]) begin
            best_rank_in[0] = fin.rank;
         end
         for (int j = 1; j < MAX_LAYERS; j++) begin
            if (!beat[j]) begin
               best_rank_in[j] = beat[j-1] ? fin.rank : best_rank_ff[j-1];
            end
         end
         // a full list drops its tail, or the newcomer if everything beats it
         if (int'(best_cnt_ff) < MAX_LAYERS) begin
            best_cnt_in = best_cnt_ff + LCNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // ascending index position of each kept entry
   // ---------------------------------------------------------------------
   always_comb begin
      logic [LPOS_W-1:0] pos;
      for (int j = 0; j < MAX_LAYERS; j++) begin
         pos = '0;
         for (int i = 0; i < MAX_LAYERS; i++) begin
            if ((LCNT_W'(i) < best_cnt_ff) && (best_idx[i] < best_idx[j])) begin
               pos = pos + LPOS_W'(1);
            end
         end
         asc_pos_in[j] = pos;
      end
   end

   // ---------------------------------------------------------------------
   // result beats
   // ---------------------------------------------------------------------
   always_comb begin
      sel_idx = '0;
      for (int j = 0; j < MAX_LAYERS; j++) begin
         sel_vec[j] = (LCNT_W'(j) < best_cnt_ff) && (asc_pos_ff[j] == emit_cnt_ff);
         if (sel_vec[j]) begin
            sel_idx = best_idx[j];
         end
      end
   end

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_vld_ff || rsp_ch.ready);
   // empty list gives one beat with found low
   assign is_last  = (best_cnt_ff == '0) ||
                     ((LCNT_W'(emit_cnt_ff) + LCNT_W'(1)) == best_cnt_ff);

   always_comb begin
      rsp_vld_in   = rsp_vld_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_load) begin
         rsp_vld_in   = 1'b1;
         rsp_idx_in   = REGION_INDEX_W'(sel_idx);
         rsp_found_in = (best_cnt_ff != '0);
         rsp_last_in  = is_last;
         rsp_count_in = LAYER_COUNT_W'(best_cnt_ff);
      end else if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.region_index = rsp_idx_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.last         = rsp_last_ff;
   assign rsp_ch.layer_count  = rsp_count_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      issue_cnt_in = issue_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      scan_num_in  = scan_num_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      hit_in       = hit_ff;
      cfg_num_in   = csr_wr_en ? csr_wr_data : cfg_num_ff;

      if (ram_rd_en) begin
         issue_cnt_in = issue_cnt_ff + NUM_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (resolve_acc) begin
               state_in     = ST_SCAN;
               issue_cnt_in = '0;
               // count above the table saturates
               scan_num_in  = (int'(cfg_num_ff) > MAX_REGIONS) ? NUM_W'(MAX_REGIONS)
                                                              : NUM_W'(cfg_num_ff);
               note_in      = req_ch.note;
               vel_in       = req_ch.velocity;
               hit_in       = req_ch.hit;
            end
         end
         ST_SCAN: begin
            // all reads issued and every entry through the insertion stage
            if (!scan_more && !pipe_busy) begin
               state_in = ST_ORDER;
            end
         end
         ST_ORDER: begin
            state_in    = ST_EMIT;
            emit_cnt_in = '0;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_cnt_in = emit_cnt_ff + LPOS_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_num_ff   <= '0;
         issue_cnt_ff <= '0;
         emit_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         stg_vld_ff   <= '0;
         best_cnt_ff  <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_num_ff   <= cfg_num_in;
         issue_cnt_ff <= issue_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         rd_vld_ff    <= rd_vld_in;
         stg_vld_ff   <= stg_vld_in;
         best_cnt_ff  <= best_cnt_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_num_ff  <= scan_num_in;
      note_ff      <= note_in;
      vel_ff       <= vel_in;
      hit_ff       <= hit_in;
      rd_idx_ff    <= rd_idx_in;
      stg_ff       <= stg_in;
      best_rank_ff <= best_rank_in;
      asc_pos_ff   <= asc_pos_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

`ifndef SYNTH
   a_wr_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_IDLE))
      else $error("table written outside idle");

   a_ins_in_scan: assert property (@(posedge clock) disable iff (reset)
      ins |-> (state_ff == ST_SCAN))
      else $error("best list insertion outside scan");

   a_order_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ORDER) |-> (!pipe_busy && (issue_cnt_ff == scan_num_ff)))
      else $error("ordering started before the scan drained");

   a_one_select: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && (best_cnt_ff != '0)) |-> $onehot(sel_vec))
      else $error("result beat does not select exactly one kept entry");

   a_list_cleared: assert property (@(posedge clock) disable iff (reset)
      resolve_acc |=> (best_cnt_ff == '0))
      else $error("best list not cleared at resolve start");
`endif

endmodule

`default_nettype wire

[verif/layer_pick_monitor.sv]
`timescale 1ns / 100ps

module layer_pick_monitor (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [rls_pkg::CFG_W-1:0] csr_wr_data,
   rls_req_if                        req_mon,
   rls_rsp_if                        rsp_mon,
   output int                        fail_count,
   output int                        outstanding,
   output int                        beats_checked,
   output int                        empty_beats
);

   import rls_pkg::*;

   typedef struct packed {
      logic [REGION_INDEX_W-1:0] region_index;
      logic                      found;
      logic                      last;
      logic [LAYER_COUNT_W-1:0]  layer_count;
   } layer_beat_type;

   region_type       regions [MAX_REGIONS];
   logic [CFG_W-1:0] in_use;
   layer_beat_type   layers_due [$];
   int               errs    = 0;
   int               beats   = 0;
   int               empties = 0;

   // narrower velocity span wins, then narrower key span, then higher index
   function automatic bit outranks(input int a, input int b);
      int va, vb, ka, kb;
      va = int'(regions[a].hi_vel) - int'(regions[a].lo_vel);
      vb = int'(regions[b].hi_vel) - int'(regions[b].lo_vel);
      if (va != vb) return va < vb;
      ka = int'(regions[a].hi_key) - int'(regions[a].lo_key);
      kb = int'(regions[b].hi_key) - int'(regions[b].lo_key);
      if (ka != kb) return ka < kb;
      return a > b;
   endfunction

   function automatic void predict_layers(input logic [KEY_W-1:0] note,
                                          input logic [VEL_W-1:0] vel,
                                          input logic [HIT_W-1:0] hit);
      int               best [MAX_LAYERS];
      int               kept [$];
      int               count, scan, pos;
      logic [HIT_W-1:0] len, slot_m1;
      layer_beat_type   nb;
      count = 0;
      scan  = (in_use > MAX_REGIONS) ? MAX_REGIONS : int'(in_use);
      for (int i = 0; i < scan; i++) begin
         len = HIT_W'(regions[i].len);
         if (len == '0) len = 1;
         slot_m1 = HIT_W'(regions[i].slot) - 1;
         if (note < regions[i].lo_key || note > regions[i].hi_key) continue;
         if (vel < regions[i].lo_vel || vel > regions[i].hi_vel) continue;
         if (regions[i].slot == '0 || (hit % len) != slot_m1) continue;
         if (count < MAX_LAYERS) begin
            pos = count;
            count++;
         end else if (outranks(i, best[count-1])) begin
            pos = count - 1;
         end else begin
            continue;
         end
         while (pos > 0 && outranks(i, best[pos-1])) begin
            best[pos] = best[pos-1];
            pos--;
         end
         best[pos] = i;
      end
      if (count == 0) begin
         nb = '{region_index: '0, found: 1'b0, last: 1'b1, layer_count: '0};
         layers_due = {layers_due, nb};
      end else begin
         for (int k = 0; k < count; k++) kept = {kept, best[k]};
         kept.sort();
         for (int k = 0; k < count; k++) begin
            nb = '{REGION_INDEX_W'(kept[k]), 1'b1, (k == count - 1),
                   LAYER_COUNT_W'(count)};
            layers_due = {layers_due, nb};
         end
      end
   endfunction

   always @(posedge clock) begin : track
      layer_beat_type got, want;
      if (reset) begin
         in_use = '0;
         layers_due.delete();
      end else begin
         if (csr_wr_en) in_use = csr_wr_data;
         // result side first: a beat never belongs to a resolve taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.region_index, rsp_mon.found, rsp_mon.last, rsp_mon.layer_count};
            beats++;
            if (!got.found) empties++;
            if (layers_due.size() == 0) begin
               errs++;
               if (errs <= 10) begin
                  $display("unexpected result beat: index %0d found %0b last %0b count %0d",
                           got.region_index, got.found, got.last, got.layer_count);
               end
            end else begin
               want = layers_due.pop_front();
               if (got.region_index !== want.region_index || got.found !== want.found ||
                   got.last !== want.last || got.layer_count !== want.layer_count) begin
                  errs++;
                  if (errs <= 10) begin
                     $display("result beat %0d: expected index %0d found %0b last %0b count %0d",
                              beats, want.region_index, want.found, want.last,
                              want.layer_count);
                     $display("result beat %0d:      got index %0d found %0b last %0b count %0d",
                              beats, got.region_index, got.found, got.last, got.layer_count);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_WRITE) begin
               if (int'(req_mon.entry_index) < MAX_REGIONS) begin
                  regions[req_mon.entry_index].lo_key = req_mon.lo_key;
                  regions[req_mon.entry_index].hi_key = req_mon.hi_key;
                  regions[req_mon.entry_index].lo_vel = req_mon.lo_vel;
                  regions[req_mon.entry_index].hi_vel = req_mon.hi_vel;
                  regions[req_mon.entry_index].len    =
                     (req_mon.cycle_length == '0) ? LEN_W'(1) : req_mon.cycle_length;
                  regions[req_mon.entry_index].slot   =
                     (req_mon.cycle_slot == '0) ? LEN_W'(1) : req_mon.cycle_slot;
               end
            end else begin
               predict_layers(req_mon.note, req_mon.velocity, req_mon.hit);
            end
         end
      end
      fail_count    <= errs;
      outstanding   <= layers_due.size();
      beats_checked <= beats;
      empty_beats   <= empties;
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import rls_pkg::*;

   // no beat may stay stuck longer than this: a full 256-entry scan plus the long hold-off
   localparam int QUIET_LIMIT   = 4000;
   // a full scan and drain of the table, used after the last expected beat
   localparam int SETTLE_CYCLES = 300;
   localparam int HOLD_CYCLES   = 600;
   localparam int PHASE_BEATS   = 6;
   localparam int PHASES        = 9;

   typedef struct {
      logic               action;
      logic [ENTRY_W-1:0] entry_index;
      logic [KEY_W-1:0]   lo_key;
      logic [KEY_W-1:0]   hi_key;
      logic [VEL_W-1:0]   lo_vel;
      logic [VEL_W-1:0]   hi_vel;
      logic [LEN_W-1:0]   cycle_length;
      logic [LEN_W-1:0]   cycle_slot;
      logic [KEY_W-1:0]   note;
      logic [VEL_W-1:0]   velocity;
      logic [HIT_W-1:0]   hit;
   } req_beat_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   int fail_count, outstanding, beats_checked, empty_beats;
   // entries 0 .. filled-1 are written; a resolve never scans past them until all are
   int filled        = 0;
   int writes_sent   = 0;
   int resolves_sent = 0;
   int settings_used = 0;
   int send_burst    = 0;
   int quiet         = 0;

   rls_req_if req_ch ();
   rls_rsp_if rsp_ch ();

   region_layer_selector u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // watches both channels and the csr port, predicts every resolve and compares
   layer_pick_monitor u_mon (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .beats_checked (beats_checked),
      .empty_beats   (empty_beats)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // every field random, so unused fields of a beat toggle too
   function automatic req_beat_type random_beat();
      req_beat_type b;
      b.action       = 1'($urandom);
      b.entry_index  = ENTRY_W'($urandom);
      b.lo_key       = KEY_W'($urandom);
      b.hi_key       = KEY_W'($urandom);
      b.lo_vel       = VEL_W'($urandom);
      b.hi_vel       = VEL_W'($urandom);
      b.cycle_length = LEN_W'($urandom);
      b.cycle_slot   = LEN_W'($urandom);
      b.note         = KEY_W'($urandom);
      b.velocity     = VEL_W'($urandom);
      b.hit          = $urandom;
      return b;
   endfunction

   // offer one beat after a random gap and hold it until the block takes it
   task automatic send_beat(input req_beat_type b);
      int gap;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else if ($urandom_range(19) == 0) begin
         gap = 0;
         send_burst = 25;
      end else begin
         gap = $urandom_range(6);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= b.action;
      req_ch.entry_index  <= b.entry_index;
      req_ch.lo_key       <= b.lo_key;
      req_ch.hi_key       <= b.hi_key;
      req_ch.lo_vel       <= b.lo_vel;
      req_ch.hi_vel       <= b.hi_vel;
      req_ch.cycle_length <= b.cycle_length;
      req_ch.cycle_slot   <= b.cycle_slot;
      req_ch.note         <= b.note;
      req_ch.velocity     <= b.velocity;
      req_ch.hit          <= b.hit;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (b.action == ACT_WRITE) begin
         writes_sent++;
         if (int'(b.entry_index) == filled) filled++;
      end else begin
         resolves_sent++;
      end
   endtask

   task automatic put_region(input int idx, input int lk, input int hk, input int lv,
                             input int hv, input int len, input int slot);
      req_beat_type b;
      b              = random_beat();
      b.action       = ACT_WRITE;
      b.entry_index  = ENTRY_W'(idx);
      b.lo_key       = KEY_W'(lk);
      b.hi_key       = KEY_W'(hk);
      b.lo_vel       = VEL_W'(lv);
      b.hi_vel       = VEL_W'(hv);
      b.cycle_length = LEN_W'(len);
      b.cycle_slot   = LEN_W'(slot);
      send_beat(b);
   endtask

   task automatic ask(input int note, input int vel, input logic [HIT_W-1:0] hit);
      req_beat_type b;
      b          = random_beat();
      b.action   = ACT_RESOLVE;
      b.note     = KEY_W'(note);
      b.velocity = VEL_W'(vel);
      b.hit      = hit;
      send_beat(b);
   endtask

   // mostly ordered ranges and short round-robin cycles so that resolves find layers;
   // the rest keep their random bounds, inverted ranges and long cycles among them
   task automatic put_random_region(input int idx);
      req_beat_type b;
      b             = random_beat();
      b.action      = ACT_WRITE;
      b.entry_index = ENTRY_W'(idx);
      if ($urandom_range(6) != 0) begin
         b.lo_key = KEY_W'($urandom_range(127));
         b.hi_key = KEY_W'($urandom_range(127, int'(b.lo_key)));
      end
      if ($urandom_range(6) != 0) begin
         b.lo_vel = VEL_W'($urandom_range(127));
         b.hi_vel = VEL_W'($urandom_range(127, int'(b.lo_vel)));
      end
      if ($urandom_range(6) != 0) begin
         b.cycle_length = LEN_W'($urandom_range(4));
         b.cycle_slot   = LEN_W'($urandom_range(int'(b.cycle_length)));
      end
      send_beat(b);
   endtask

   // stop offering, wait for every predicted beat, then let a full scan time pass
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // regions_in_use, only written while the block is idle
   task automatic set_regions(input int v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_W'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      req_beat_type b;
      int           v;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.action       <= ACT_WRITE;
      req_ch.entry_index  <= '0;
      req_ch.lo_key       <= '0;
      req_ch.hi_key       <= '0;
      req_ch.lo_vel       <= '0;
      req_ch.hi_vel       <= '0;
      req_ch.cycle_length <= '0;
      req_ch.cycle_slot   <= '0;
      req_ch.note         <= '0;
      req_ch.velocity     <= '0;
      req_ch.hit          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // nothing in use after reset: a single empty beat
      ask(64, 64, 32'h0);

      // directed table
      put_region(0, 0, 127, 0, 127, 0, 0);       // zero length and slot clamp to one
      put_region(1, 0, 127, 0, 127, 1, 1);       // full range, ties entry 0 on both spans
      put_region(2, 60, 70, 60, 70, 1, 1);
      put_region(3, 64, 64, 64, 64, 1, 1);       // narrowest possible region
      put_region(4, 70, 60, 0, 127, 1, 1);       // inverted key range
      put_region(5, 0, 127, 100, 20, 1, 1);      // inverted velocity range
      put_region(6, 0, 127, 50, 80, 255, 255);   // longest cycle, last slot
      put_region(7, 0, 127, 0, 127, 2, 2);       // odd hits only
      put_region(8, 40, 90, 40, 90, 2, 1);       // even hits only
      put_region(9, 64, 127, 64, 127, 3, 3);
      put_region(10, 0, 64, 0, 64, 4, 5);        // slot beyond the cycle never fires
      put_region(11, 0, 127, 1, 127, 1, 1);
      put_region(12, 30, 100, 30, 100, 1, 1);    // three equal regions: index breaks the tie
      put_region(13, 30, 100, 30, 100, 1, 1);
      put_region(14, 30, 100, 30, 100, 1, 1);
      drain();
      set_regions(filled);

      ask(64, 64, 32'h0);             // nine candidates, entry 0 (tied widest, lower index) drops out
      ask(64, 64, 32'hFFFF_FFFF);     // all-ones hit counter
      ask(0, 0, 32'd254);             // lowest note and velocity
      ask(127, 127, 32'd5);           // highest note and velocity
      ask(64, 70, 32'd254);           // long cycle hits its last slot
      ask(127, 0, 32'd3);

      // random phases, each under its own region count
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: v = filled;
            1: v = $urandom_range(filled, 1);
            2: begin
               // write the rest of the table so that any count becomes legal
               for (int i = filled; i < MAX_REGIONS; i++) put_random_region(i);
               v = MAX_REGIONS;
            end
            3: v = (1 << CFG_W) - 1;        // all csr bits set, saturates to the table size
            4: v = 0;
            5: v = MAX_REGIONS + 1;
            6: v = $urandom_range(MAX_REGIONS - 1, 1);
            7: v = 1;
            default: v = MAX_REGIONS;
         endcase
         drain();
         set_regions(v);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            if ($urandom_range(9) < 3) begin
               // overwrite a written entry or extend the written run by one
               put_random_region($urandom_range(filled < MAX_REGIONS ? filled
                                                                     : MAX_REGIONS - 1));
            end else begin
               b        = random_beat();
               b.action = ACT_RESOLVE;
               // short counters hit the small cycles, the ends of the range wrap them
               case ($urandom_range(3))
                  0: ;
                  1: b.hit = HIT_W'($urandom_range(15));
                  2: b.hit = '1 - HIT_W'($urandom_range(15));
                  default: b.hit = HIT_W'($urandom_range(1000));
               endcase
               send_beat(b);
            end
         end
      end
      drain();

      $display("covered %0d table writes and %0d resolves under %0d region counts",
               writes_sent, resolves_sent, settings_used);
      $display("checked %0d result beats, %0d of them empty", beats_checked, empty_beats);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[region_layer_selector] OK");
      end else begin
         $display("[region_layer_selector] ERROR");
      end
      $finish;
   end

   // result side: random stalls per beat, bursts with none, and two long hold-offs
   initial begin : result_sink
      int taken, wait_cycles, burst;
      taken = 0;
      burst = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken == 5 || taken == 100) begin
            // block parks its beat and stops taking input while the sender keeps offering
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (burst > 0) begin
            wait_cycles = 0;
            burst--;
         end else if ($urandom_range(19) == 0) begin
            wait_cycles = 0;
            burst = 30;
         end else begin
            wait_cycles = $urandom_range(6);
         end
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         taken++;
      end
   end

   // watchdog on cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("no beat moved for %0d cycles, %0d results still due", quiet, outstanding);
         $display("[region_layer_selector] ERROR");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

endmodule
